// ----- rtl/bis_pkg.sv -----
// Shared constants and types for the bilinear image sampler.
package bis_pkg;

	localparam int DEF_MAX_WIDTH  = 256;
	localparam int DEF_MAX_HEIGHT = 256;
	localparam int DEF_FRAC_BITS  = 8;

	localparam int PIX_W     = 8;
	localparam int COORD_W   = 16;
	localparam int VALUE_W   = 16;
	localparam int CFG_W     = 9;
	localparam int CFG_IDX_W = 1;
	// integer coordinate width: 16-bit coordinate plus room for the width compare
	localparam int CW        = 17;
	localparam int NUM_BANKS = 4;
	localparam int BANK_W    = 2;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

	localparam logic [CFG_W-1:0] CFG_DIM_RESET = 9'd256;

	localparam logic OP_WRITE  = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	localparam logic [VALUE_W-1:0] VALUE_MAX = 16'hFFFF;

	typedef struct packed {
		logic              wr_en;
		logic [BANK_W-1:0] wr_bank;
		logic              rd_en;
	} mem_ctl_t;

endpackage

// ----- rtl/bis_if.sv -----
// Request and result channel interfaces of the bilinear image sampler.
interface bis_in_if;
	import bis_pkg::*;
	logic               valid;
	logic               ready;
	logic               op;
	logic [PIX_W-1:0]   write_row;
	logic [PIX_W-1:0]   write_col;
	logic [PIX_W-1:0]   write_value;
	logic [COORD_W-1:0] x_coord;
	logic [COORD_W-1:0] y_coord;

	modport source (output valid, op, write_row, write_col, write_value, x_coord, y_coord,
		input ready);
	modport sink (input valid, op, write_row, write_col, write_value, x_coord, y_coord,
		output ready);
endinterface

interface bis_out_if;
	import bis_pkg::*;
	logic               valid;
	logic               ready;
	logic [VALUE_W-1:0] value;
	logic               coord_error;

	modport source (output valid, value, coord_error, input ready);
	modport sink (input valid, value, coord_error, output ready);
endinterface

// ----- rtl/bis_pix_mem.sv -----
// Four-bank pixel store, banked by row and column parity, registered reads.
module bis_pix_mem #(
	parameter int AW = 14
) (
	input  logic                                   clk,
	input  bis_pkg::mem_ctl_t                      ctl,
	input  logic [AW-1:0]                          wr_addr,
	input  logic [bis_pkg::PIX_W-1:0]              wr_data,
	input  logic [bis_pkg::NUM_BANKS-1:0][AW-1:0]  rd_addr,
	output logic [bis_pkg::NUM_BANKS-1:0][bis_pkg::PIX_W-1:0] rd_data
);
	import bis_pkg::*;

	for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
		logic [PIX_W-1:0] mem_q [2**AW];
		logic [PIX_W-1:0] rd_q;

		always_ff @(posedge clk) begin
			if (ctl.wr_en && ctl.wr_bank == BANK_W'(b)) begin
				mem_q[wr_addr] <= wr_data;
			end
			if (ctl.rd_en) begin
				rd_q <= mem_q[rd_addr[b]];
			end
		end

		assign rd_data[b] = rd_q;
	end

endmodule

// ----- rtl/bilinear_image_sampler_unit.sv -----
// Bilinear image sampler: banked pixel store and five-stage interpolation pipeline.
//
//  channel  dir  payload                                          accepted when
//  req      in   op, write_row, write_col, write_value, x/y_coord valid & ready
//  rsp      out  value, coord_error                               valid & ready
//  cfg      in   cfg_index, cfg_wdata                             cfg_we
//
// One request per cycle unless rsp stalls. A sample's result passes stage registers
// s1 to s5 before it is offered; writes give no result. Four parity banks give one
// read port each, so the four neighbours are read in the same cycle. Reset clears
// valid bits and sets width/height to 256; the pixel store is not cleared. Each stage
// holds while the one after it is full and stalled, bubbles are squeezed out.
module bilinear_image_sampler_unit #(
	parameter int MAX_WIDTH  = bis_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = bis_pkg::DEF_MAX_HEIGHT,
	parameter int FRAC_BITS  = bis_pkg::DEF_FRAC_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [bis_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bis_pkg::CFG_W-1:0]     cfg_wdata,
	bis_in_if.sink                        req,
	bis_out_if.source                     rsp
);
	import bis_pkg::*;

	localparam int RW     = $clog2(MAX_WIDTH);
	localparam int RH     = $clog2(MAX_HEIGHT);
	localparam int AW_RAW = RW + RH - 2;
	localparam int AW     = (AW_RAW < 1) ? 1 : AW_RAW;
	localparam int QW     = PIX_W + FRAC_BITS;
	localparam int PYW    = FRAC_BITS + 10;
	localparam int PW     = 2 * FRAC_BITS + 10;

	function automatic logic [AW-1:0] bank_addr(input logic [CW-1:0] row,
		input logic [CW-1:0] col);
		logic [31:0] lin;
		lin = ((32'(row) >> 1) << (RW - 1)) | (32'(col) >> 1);
		return lin[AW-1:0];
	endfunction

	// column lerp: a*2^F + f*(b - a)
	function automatic logic [QW-1:0] lerp_y(input logic [PIX_W-1:0] a,
		input logic [PIX_W-1:0] b, input logic [FRAC_BITS-1:0] f);
		logic signed [PYW-1:0] d;
		logic signed [PYW-1:0] s;
		d = PYW'($signed({1'b0, b}) - $signed({1'b0, a}));
		s = PYW'($signed({1'b0, f})) * d;
		s = s + $signed(PYW'(a) << FRAC_BITS);
		return s[QW-1:0];
	endfunction

	// configuration
	logic [CFG_W-1:0] image_width_q, image_height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= CFG_DIM_RESET;
			image_height_q <= CFG_DIM_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH:  image_width_q  <= cfg_wdata;
				REG_IMAGE_HEIGHT: image_height_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// stage enables
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic en1, en2, en3, en4, en5;

	// stage 1 request register contents
	logic               op_s1;
	logic [PIX_W-1:0]   wrow_s1, wcol_s1, wval_s1;
	logic [COORD_W-1:0] x_s1, y_s1;

	assign en5 = !v_s5 || rsp.ready;
	assign en4 = !v_s4 || en5;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign req.ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en1) v_s1 <= req.valid;
			if (en2) v_s2 <= v_s1 && (op_s1 == OP_SAMPLE);
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
		end
	end

	// stage 1: request register
	always_ff @(posedge clk) begin
		if (en1) begin
			op_s1   <= req.op;
			wrow_s1 <= req.write_row;
			wcol_s1 <= req.write_col;
			wval_s1 <= req.write_value;
			x_s1    <= req.x_coord;
			y_s1    <= req.y_coord;
		end
	end

	// stage 1 logic: bounds, edge clamp, bank addressing
	logic [CW-1:0] w_c, h_c, xi_c, yi_c, x2_c, y2_c;
	logic          err_c, wr_in_c;
	logic [NUM_BANKS-1:0][AW-1:0] rd_addr_c;
	logic [AW-1:0] wr_addr_c;
	mem_ctl_t      mem_ctl;

	always_comb begin
		logic [CW-1:0] rrow, rcol;
		w_c = (CW'(image_width_q) > CW'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : CW'(image_width_q);
		h_c = (CW'(image_height_q) > CW'(MAX_HEIGHT)) ? CW'(MAX_HEIGHT) : CW'(image_height_q);
		xi_c = CW'(x_s1 >> FRAC_BITS);
		yi_c = CW'(y_s1 >> FRAC_BITS);
		err_c = (xi_c >= w_c) || (yi_c >= h_c);
		x2_c = (xi_c + CW'(1) == w_c) ? xi_c : xi_c + CW'(1);
		y2_c = (yi_c + CW'(1) == h_c) ? yi_c : yi_c + CW'(1);
		for (int b = 0; b < NUM_BANKS; b++) begin
			rrow = (yi_c[0] == 1'(b >> 1)) ? yi_c : y2_c;
			rcol = (xi_c[0] == 1'(b)) ? xi_c : x2_c;
			rd_addr_c[b] = bank_addr(rrow, rcol);
		end
		wr_in_c = (32'(wrow_s1) < 32'(MAX_HEIGHT)) && (32'(wcol_s1) < 32'(MAX_WIDTH));
		wr_addr_c = bank_addr(CW'(wrow_s1), CW'(wcol_s1));
		mem_ctl.wr_en   = v_s1 && (op_s1 == OP_WRITE) && wr_in_c && en2;
		mem_ctl.wr_bank = {wrow_s1[0], wcol_s1[0]};
		mem_ctl.rd_en   = en2;
	end

	logic [NUM_BANKS-1:0][PIX_W-1:0] pix_rd;

	bis_pix_mem #(
		.AW(AW)
	) u_mem (
		.clk     (clk),
		.ctl     (mem_ctl),
		.wr_addr (wr_addr_c),
		.wr_data (wval_s1),
		.rd_addr (rd_addr_c),
		.rd_data (pix_rd)
	);

	// stage 2: pixels from the store
	logic                 err_s2, yp_s2, y2p_s2, xp_s2, x2p_s2;
	logic [FRAC_BITS-1:0] fx_s2, fy_s2;

	always_ff @(posedge clk) begin
		if (en2) begin
			err_s2 <= err_c;
			yp_s2  <= yi_c[0];
			y2p_s2 <= y2_c[0];
			xp_s2  <= xi_c[0];
			x2p_s2 <= x2_c[0];
			fx_s2  <= x_s1[FRAC_BITS-1:0];
			fy_s2  <= y_s1[FRAC_BITS-1:0];
		end
	end

	logic [PIX_W-1:0] p_tl, p_bl, p_tr, p_br;

	assign p_tl = pix_rd[{yp_s2, xp_s2}];
	assign p_bl = pix_rd[{y2p_s2, xp_s2}];
	assign p_tr = pix_rd[{yp_s2, x2p_s2}];
	assign p_br = pix_rd[{y2p_s2, x2p_s2}];

	// stage 3: column results
	logic [QW-1:0]        q1_s3, q2_s3;
	logic [FRAC_BITS-1:0] fx_s3;
	logic                 err_s3;

	always_ff @(posedge clk) begin
		if (en3) begin
			q1_s3  <= lerp_y(p_tl, p_bl, fy_s2);
			q2_s3  <= lerp_y(p_tr, p_br, fy_s2);
			fx_s3  <= fx_s2;
			err_s3 <= err_s2;
		end
	end

	logic signed [QW:0]   dq_c;
	logic signed [PW-1:0] prod_c;

	assign dq_c   = (QW+1)'($signed({1'b0, q2_s3}) - $signed({1'b0, q1_s3}));
	assign prod_c = PW'($signed({1'b0, fx_s3})) * PW'(dq_c);

	// stage 4: row product
	logic signed [PW-1:0] prod_s4;
	logic [QW-1:0]        q1_s4;
	logic                 err_s4;

	always_ff @(posedge clk) begin
		if (en4) begin
			prod_s4 <= prod_c;
			q1_s4   <= q1_s3;
			err_s4  <= err_s3;
		end
	end

	logic signed [PW-1:0] acc_c;
	logic [31:0]          res_c;
	logic [VALUE_W-1:0]   value_c;

	always_comb begin
		acc_c = $signed(PW'(q1_s4) << FRAC_BITS) + prod_s4;
		res_c = 32'(acc_c[PW-1:FRAC_BITS]);
		if (err_s4 || acc_c[PW-1]) begin
			value_c = '0;
		end else if (res_c > 32'(VALUE_MAX)) begin
			value_c = VALUE_MAX;
		end else begin
			value_c = res_c[VALUE_W-1:0];
		end
	end

	// stage 5: result register
	logic [VALUE_W-1:0] value_s5;
	logic               err_s5;

	always_ff @(posedge clk) begin
		if (en5) begin
			value_s5 <= value_c;
			err_s5   <= err_s4;
		end
	end

	assign rsp.valid       = v_s5;
	assign rsp.value       = value_s5;
	assign rsp.coord_error = err_s5;

	// checks
	a_write_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && (op_s1 == OP_WRITE) && en2 |=> !v_s2)
		else $error("write request reached the interpolation stages");

	a_full_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && v_s2 && v_s3 && v_s4 && v_s5 && !rsp.ready |-> !req.ready)
		else $error("full pipeline accepted a request under stall");

	a_stall_holds_s4: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && !en5 |=> v_s4 && $stable(prod_s4) && $stable(q1_s4))
		else $error("stage 4 changed while stalled");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && err_s4 && en5 |=> rsp.valid && rsp.coord_error && rsp.value == '0)
		else $error("coordinate error result carries a nonzero value");

endmodule
